### hdl/per_row_palette_store_core_defines.svh
// Assertion macros used by the palette store back end.
`ifndef PER_ROW_PALETTE_STORE_CORE_DEFINES_SVH
`define PER_ROW_PALETTE_STORE_CORE_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define PRS_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define PRS_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/prs_pkg.sv
package prs_pkg;

  localparam int ROWS_DEFAULT  = 240;
  localparam int ROW_COLORS    = 16;
  localparam int GLOBAL_BASE   = 16;
  localparam int GBANK_WORDS   = 240;
  localparam int QUEUE_DEPTH   = 2;

  localparam int ROW_W      = 8;
  localparam int IDX_W      = 4;
  localparam int ROW_ADDR_W = ROW_W + IDX_W;
  localparam int GIDX_W     = 8;
  localparam int COLOR_W    = 32;

  localparam logic [COLOR_W-1:0] OPAQUE_BLACK = 32'hFF000000;

  typedef enum logic [2:0] {
    OP_WR_ROW,
    OP_WR_ALL,
    OP_WR_GLOBAL,
    OP_RD_ROW,
    OP_RD_GLOBAL,
    OP_PRESET_ALL,
    OP_PRESET_ROWS,
    OP_CLEAR_DIRTY
  } op_t;

  typedef enum logic [1:0] {
    PRE_RGBI,
    PRE_HOME,
    PRE_GRAY,
    PRE_CUBE
  } preset_t;

  typedef struct packed {
    op_t                op;
    logic [ROW_W-1:0]   row;
    logic [ROW_W-1:0]   last_row;
    logic [GIDX_W-1:0]  color_index;
    logic [COLOR_W-1:0] color;
    preset_t            preset;
  } item_t;

  typedef struct packed {
    logic [COLOR_W-1:0] read_data;
    logic               dirty;
  } result_t;

  // Work classes handed from the front to the back
  typedef enum logic [3:0] {
    K_NONE,
    K_CLEAR,
    K_WR_ROW,
    K_WR_GLOBAL,
    K_RD_ROW,
    K_RD_GLOBAL,
    K_BCAST,
    K_FILL_ROWS,
    K_FILL_CUBE
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [ROW_W-1:0]   first_row;
    logic [ROW_W-1:0]   last_row;
    logic [IDX_W-1:0]   idx;
    logic [GIDX_W-1:0]  gidx;
    logic [COLOR_W-1:0] color;
    preset_t            preset;
  } qcmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } queue_status_t;

  typedef enum logic [1:0] {
    BS_INIT,
    BS_IDLE,
    BS_READ,
    BS_FILL
  } back_state_t;

  localparam logic [COLOR_W-1:0] RGBI_COLORS [ROW_COLORS] = '{
    32'hFF000000, 32'hFF0000AA, 32'hFF00AA00, 32'hFF00AAAA,
    32'hFFAA0000, 32'hFFAA00AA, 32'hFFAA5500, 32'hFFAAAAAA,
    32'hFF555555, 32'hFF5555FF, 32'hFF55FF55, 32'hFF55FFFF,
    32'hFFFF5555, 32'hFFFF55FF, 32'hFFFFFF55, 32'hFFFFFFFF
  };

  localparam logic [COLOR_W-1:0] HOME_COLORS [ROW_COLORS] = '{
    32'hFF000000, 32'hFFFFFFFF, 32'hFF880000, 32'hFFAAFFEE,
    32'hFFCC44CC, 32'hFF00CC55, 32'hFF0000AA, 32'hFFEEEE77,
    32'hFFDD8855, 32'hFF664400, 32'hFFFF7777, 32'hFF333333,
    32'hFF777777, 32'hFFAAFF66, 32'hFF0088FF, 32'hFFBBBBBB
  };

  function automatic logic [COLOR_W-1:0] preset_color(preset_t p, logic [IDX_W-1:0] k);
    logic [7:0] lvl;
    lvl = {k, k}; // k * 17
    case (p)
      PRE_RGBI: preset_color = RGBI_COLORS[k];
      PRE_HOME: preset_color = HOME_COLORS[k];
      default:  preset_color = OPAQUE_BLACK | {8'h00, lvl, lvl, lvl};
    endcase
  endfunction

  // Cube levels: r*255/5, g*255/7, b*255/4
  function automatic logic [7:0] cube_red(logic [2:0] r);
    case (r)
      3'd0:    cube_red = 8'd0;
      3'd1:    cube_red = 8'd51;
      3'd2:    cube_red = 8'd102;
      3'd3:    cube_red = 8'd153;
      3'd4:    cube_red = 8'd204;
      3'd5:    cube_red = 8'd255;
      default: cube_red = 8'd0;
    endcase
  endfunction

  function automatic logic [7:0] cube_green(logic [2:0] g);
    case (g)
      3'd0:    cube_green = 8'd0;
      3'd1:    cube_green = 8'd36;
      3'd2:    cube_green = 8'd72;
      3'd3:    cube_green = 8'd109;
      3'd4:    cube_green = 8'd145;
      3'd5:    cube_green = 8'd182;
      3'd6:    cube_green = 8'd218;
      default: cube_green = 8'd255;
    endcase
  endfunction

  function automatic logic [7:0] cube_blue(logic [2:0] b);
    case (b)
      3'd0:    cube_blue = 8'd0;
      3'd1:    cube_blue = 8'd63;
      3'd2:    cube_blue = 8'd127;
      3'd3:    cube_blue = 8'd191;
      3'd4:    cube_blue = 8'd255;
      default: cube_blue = 8'd0;
    endcase
  endfunction

endpackage

### hdl/per_row_palette_store_core.sv
// The result strobe is registered: writes, clear and out-of-range reads pass the queue slot
// and the done register; reads also pass the read state, and a row fill waits for its writes
// (16 per row, 1 per row for broadcast), the cube load for its writes to the global bank.
// Single writes sustain one item per cycle while no read or fill holds the back end; a 2-entry
// queue lets items queue behind a fill, and busy rises when it is full. Synchronous reset loads
// the RGBI set into every row and the cube into the global bank: busy stays high until both are swept.
module per_row_palette_store_core #(
  parameter int ROWS = prs_pkg::ROWS_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  prs_pkg::item_t   cmd,
  output logic             done,
  output prs_pkg::result_t result
);
  import prs_pkg::*;

  logic          push;
  logic          pop;
  logic          initializing;
  qcmd_t         qcmd;
  qcmd_t         head;
  queue_status_t qstat;

  prs_front #(.ROWS(ROWS)) u_front (
    .start        (start),
    .cmd          (cmd),
    .qstat        (qstat),
    .initializing (initializing),
    .busy         (busy),
    .push         (push),
    .qcmd         (qcmd)
  );

  prs_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (qcmd),
    .pop       (pop),
    .head      (head),
    .qstat     (qstat)
  );

  prs_back #(.ROWS(ROWS)) u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .qstat        (qstat),
    .pop          (pop),
    .initializing (initializing),
    .done         (done),
    .result       (result)
  );

endmodule

### hdl/prs_ram.sv
module prs_ram #(
  parameter int WIDTH = prs_pkg::COLOR_W,
  parameter int DEPTH = prs_pkg::ROW_COLORS,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/prs_queue.sv
module prs_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  prs_pkg::qcmd_t         push_data,
  input  logic                   pop,
  output prs_pkg::qcmd_t         head,
  output prs_pkg::queue_status_t qstat
);
  import prs_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PW-1:0] LAST_SLOT = PW'(QUEUE_DEPTH - 1);

  qcmd_t         slots [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign head        = slots[rd_ptr];
  assign qstat.empty = (count == '0);
  assign qstat.full  = (count == CW'(QUEUE_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

### hdl/prs_front.sv
module prs_front #(
  parameter int ROWS = prs_pkg::ROWS_DEFAULT
) (
  input  logic                   start,
  input  prs_pkg::item_t         cmd,
  input  prs_pkg::queue_status_t qstat,
  input  logic                   initializing,
  output logic                   busy,
  output logic                   push,
  output prs_pkg::qcmd_t         qcmd
);
  import prs_pkg::*;

  localparam logic [ROW_W-1:0]  LAST_ROW = ROW_W'(ROWS - 1);
  localparam logic [GIDX_W-1:0] GBASE    = GIDX_W'(GLOBAL_BASE);
  localparam logic [GIDX_W-1:0] IDX_MAX  = GIDX_W'(ROW_COLORS - 1);

  logic [ROW_W-1:0] wrow;
  logic [ROW_W-1:0] lrow;
  logic [IDX_W-1:0] widx;

  assign busy = qstat.full || initializing;
  assign push = start && !busy;

  always_comb begin
    wrow = (cmd.row > LAST_ROW) ? LAST_ROW : cmd.row;
    lrow = (cmd.last_row > LAST_ROW) ? LAST_ROW : cmd.last_row;
    widx = (cmd.color_index > IDX_MAX) ? IDX_MAX[IDX_W-1:0] : cmd.color_index[IDX_W-1:0];
  end

  always_comb begin
    qcmd           = '0;
    qcmd.kind      = K_NONE;
    qcmd.color     = cmd.color;
    qcmd.preset    = cmd.preset;
    qcmd.first_row = wrow;
    qcmd.last_row  = lrow;
    qcmd.idx       = widx;
    unique case (cmd.op)
      OP_WR_ROW: begin
        qcmd.kind = K_WR_ROW;
      end
      OP_WR_ALL: begin
        qcmd.kind      = K_BCAST;
        qcmd.first_row = '0;
        qcmd.last_row  = LAST_ROW;
      end
      OP_WR_GLOBAL: begin
        qcmd.kind = K_WR_GLOBAL;
        qcmd.gidx = (cmd.color_index < GBASE) ? '0 : cmd.color_index - GBASE;
      end
      OP_RD_ROW: begin
        // out-of-range reads just return zero
        if (cmd.row <= LAST_ROW && cmd.color_index <= IDX_MAX) begin
          qcmd.kind      = K_RD_ROW;
          qcmd.first_row = cmd.row;
          qcmd.idx       = cmd.color_index[IDX_W-1:0];
        end
      end
      OP_RD_GLOBAL: begin
        if (cmd.color_index >= GBASE) begin
          qcmd.kind = K_RD_GLOBAL;
          qcmd.gidx = cmd.color_index - GBASE;
        end
      end
      OP_PRESET_ALL: begin
        qcmd.first_row = '0;
        qcmd.last_row  = LAST_ROW;
        qcmd.kind      = (cmd.preset == PRE_CUBE) ? K_FILL_CUBE : K_FILL_ROWS;
      end
      OP_PRESET_ROWS: begin
        // cube on a row range is a no-op
        if (cmd.preset != PRE_CUBE) begin
          qcmd.kind = K_FILL_ROWS;
          if (wrow > lrow) begin
            qcmd.first_row = lrow;
            qcmd.last_row  = wrow;
          end
        end
      end
      OP_CLEAR_DIRTY: begin
        qcmd.kind = K_CLEAR;
      end
    endcase
  end

endmodule

### hdl/prs_back.sv
`include "per_row_palette_store_core_defines.svh"

module prs_back #(
  parameter int ROWS = prs_pkg::ROWS_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  prs_pkg::qcmd_t         head,
  input  prs_pkg::queue_status_t qstat,
  output logic                   pop,
  output logic                   initializing,
  output logic                   done,
  output prs_pkg::result_t       result
);
  import prs_pkg::*;

  localparam int RAW = $clog2(ROWS * ROW_COLORS);
  localparam int GAW = $clog2(GBANK_WORDS);
  localparam logic [ROW_W-1:0] LAST_ROW  = ROW_W'(ROWS - 1);
  localparam logic [GAW-1:0]   LAST_GIDX = GAW'(GBANK_WORDS - 1);

  back_state_t state, state_next;
  logic        dirty_flag, dirty_next;
  logic        rd_global;
  logic        done_next;
  result_t     result_next;

  // row fill engine: broadcasts and preset loads
  logic               rfill_active;
  logic [ROW_W-1:0]   rfill_row;
  logic [ROW_W-1:0]   rfill_last;
  logic [IDX_W-1:0]   rfill_idx;
  logic               rfill_bcast;
  preset_t            rfill_preset;
  logic [COLOR_W-1:0] rfill_color;

  // cube fill engine for the global bank
  logic             cube_active;
  logic [GAW-1:0]   cube_addr;
  logic [2:0]       cube_r;
  logic [2:0]       cube_g;
  logic [2:0]       cube_b;

  logic                  engines_idle;
  logic [ROW_ADDR_W-1:0] row_wfull;
  logic [ROW_ADDR_W-1:0] row_rfull;

  logic               row_we;
  logic [RAW-1:0]     row_waddr;
  logic [COLOR_W-1:0] row_wdata;
  logic [COLOR_W-1:0] row_rdata;
  logic               glb_we;
  logic [GAW-1:0]     glb_waddr;
  logic [COLOR_W-1:0] glb_wdata;
  logic [COLOR_W-1:0] glb_rdata;

  assign pop          = (state == BS_IDLE) && !qstat.empty;
  assign initializing = (state == BS_INIT);
  assign engines_idle = !rfill_active && !cube_active;
  assign row_rfull    = {head.first_row, head.idx};

  prs_ram #(.WIDTH(COLOR_W), .DEPTH(ROWS * ROW_COLORS)) u_row_ram (
    .clk   (clk),
    .we    (row_we),
    .waddr (row_waddr),
    .wdata (row_wdata),
    .raddr (row_rfull[RAW-1:0]),
    .rdata (row_rdata)
  );

  prs_ram #(.WIDTH(COLOR_W), .DEPTH(GBANK_WORDS)) u_glb_ram (
    .clk   (clk),
    .we    (glb_we),
    .waddr (glb_waddr),
    .wdata (glb_wdata),
    .raddr (head.gidx[GAW-1:0]),
    .rdata (glb_rdata)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      BS_INIT: begin
        if (engines_idle) state_next = BS_IDLE;
      end
      BS_IDLE: begin
        if (pop) begin
          case (head.kind) inside
            K_RD_ROW, K_RD_GLOBAL:             state_next = BS_READ;
            K_BCAST, K_FILL_ROWS, K_FILL_CUBE: state_next = BS_FILL;
            default:                           state_next = BS_IDLE;
          endcase
        end
      end
      BS_READ: begin
        state_next = BS_IDLE;
      end
      BS_FILL: begin
        if (engines_idle) state_next = BS_IDLE;
      end
    endcase
  end

  always_comb begin
    dirty_next = dirty_flag;
    if (pop) begin
      case (head.kind) inside
        K_CLEAR:                                                  dirty_next = 1'b0;
        K_WR_ROW, K_WR_GLOBAL, K_BCAST, K_FILL_ROWS, K_FILL_CUBE: dirty_next = 1'b1;
        default:                                                  dirty_next = dirty_flag;
      endcase
    end

    row_wfull = {rfill_row, rfill_idx};
    row_we    = 1'b0;
    row_wdata = rfill_bcast ? rfill_color : preset_color(rfill_preset, rfill_idx);
    if (rfill_active) begin
      row_we = 1'b1;
    end else if (pop && head.kind == K_WR_ROW) begin
      row_we    = 1'b1;
      row_wfull = {head.first_row, head.idx};
      row_wdata = head.color;
    end
    row_waddr = row_wfull[RAW-1:0];

    glb_we    = 1'b0;
    glb_waddr = cube_addr;
    glb_wdata = {8'hFF, cube_red(cube_r), cube_green(cube_g), cube_blue(cube_b)};
    if (cube_active) begin
      glb_we = 1'b1;
    end else if (pop && head.kind == K_WR_GLOBAL) begin
      glb_we    = 1'b1;
      glb_waddr = head.gidx[GAW-1:0];
      glb_wdata = head.color;
    end

    done_next             = 1'b0;
    result_next.read_data = '0;
    result_next.dirty     = dirty_flag;
    unique case (state)
      BS_IDLE: begin
        if (pop) begin
          case (head.kind) inside
            K_NONE, K_CLEAR, K_WR_ROW, K_WR_GLOBAL: done_next = 1'b1;
            default:                                done_next = 1'b0;
          endcase
          result_next.dirty = dirty_next;
        end
      end
      BS_READ: begin
        done_next             = 1'b1;
        result_next.read_data = rd_global ? glb_rdata : row_rdata;
      end
      BS_FILL: begin
        done_next = engines_idle;
      end
      BS_INIT: begin
        done_next = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= BS_INIT;
      dirty_flag <= 1'b1;
      done       <= 1'b0;
    end else begin
      state      <= state_next;
      dirty_flag <= dirty_next;
      done       <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
    if (pop) begin
      rd_global <= (head.kind == K_RD_GLOBAL);
    end
  end

  // reset loads the RGBI set into every row and the cube into the global bank
  always_ff @(posedge clk) begin
    if (rst) begin
      rfill_active <= 1'b1;
      rfill_row    <= '0;
      rfill_last   <= LAST_ROW;
      rfill_idx    <= '0;
      rfill_bcast  <= 1'b0;
      rfill_preset <= PRE_RGBI;
      rfill_color  <= '0;
    end else if (rfill_active) begin
      if (rfill_bcast || rfill_idx == IDX_W'(ROW_COLORS - 1)) begin
        if (!rfill_bcast) rfill_idx <= '0;
        if (rfill_row == rfill_last) begin
          rfill_active <= 1'b0;
        end else begin
          rfill_row <= rfill_row + 1'b1;
        end
      end else begin
        rfill_idx <= rfill_idx + 1'b1;
      end
    end else if (pop && (head.kind == K_BCAST || head.kind == K_FILL_ROWS)) begin
      rfill_active <= 1'b1;
      rfill_row    <= head.first_row;
      rfill_last   <= head.last_row;
      rfill_bcast  <= (head.kind == K_BCAST);
      rfill_idx    <= (head.kind == K_BCAST) ? head.idx : '0;
      rfill_preset <= head.preset;
      rfill_color  <= head.color;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cube_active <= 1'b1;
      cube_addr   <= '0;
      cube_r      <= '0;
      cube_g      <= '0;
      cube_b      <= '0;
    end else if (cube_active) begin
      cube_addr <= cube_addr + 1'b1;
      if (cube_b == 3'd4) begin
        cube_b <= '0;
        if (cube_g == 3'd7) begin
          cube_g <= '0;
          cube_r <= cube_r + 1'b1;
        end else begin
          cube_g <= cube_g + 1'b1;
        end
      end else begin
        cube_b <= cube_b + 1'b1;
      end
      if (cube_addr == LAST_GIDX) cube_active <= 1'b0;
    end else if (pop && head.kind == K_FILL_CUBE) begin
      cube_active <= 1'b1;
      cube_addr   <= '0;
      cube_r      <= '0;
      cube_g      <= '0;
      cube_b      <= '0;
    end
  end

  `PRS_ASSERT_IMP(a_fill_owns_ram, clk, rst, rfill_active || cube_active, state == BS_INIT || state == BS_FILL, "fill engine running outside a fill state")
  `PRS_ASSERT_IMP(a_fill_row_range, clk, rst, rfill_active, rfill_row <= LAST_ROW && rfill_last <= LAST_ROW, "fill engine row past last row")
  `PRS_ASSERT_NXT(a_read_answers, clk, rst, state == BS_READ, done, "read finished without a result")
  `PRS_ASSERT_NXT(a_clear_reports, clk, rst, pop && head.kind == K_CLEAR, done && !result.dirty, "clear did not report a clean palette")

endmodule

### bench/per_row_palette_store_core_test.sv
module per_row_palette_store_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import prs_pkg::*;

  localparam int ROWS = ROWS_DEFAULT;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int RANDOM_ITEMS = 500;

  // Shadow copy of the palette: predicts read data and dirty flag per item
  class palette_shadow;
    logic [COLOR_W-1:0] row_words [ROWS][ROW_COLORS];
    logic [COLOR_W-1:0] global_words [GBANK_WORDS];
    logic changed;
    result_t pending_words [$];
    int unsigned errors;
    int unsigned checked;
    int unsigned op_tally [8];

    function new();
      fill_rows(PRE_RGBI, 0, ROWS - 1);
      load_cube();
      changed = 1'b1;
      errors = 0;
      checked = 0;
      foreach (op_tally[i]) op_tally[i] = 0;
    endfunction

    function logic [COLOR_W-1:0] tone(preset_t p, int k);
      logic [COLOR_W-1:0] rgbi [ROW_COLORS];
      logic [COLOR_W-1:0] home [ROW_COLORS];
      logic [7:0] lvl;
      rgbi = '{32'hFF000000, 32'hFF0000AA, 32'hFF00AA00, 32'hFF00AAAA,
               32'hFFAA0000, 32'hFFAA00AA, 32'hFFAA5500, 32'hFFAAAAAA,
               32'hFF555555, 32'hFF5555FF, 32'hFF55FF55, 32'hFF55FFFF,
               32'hFFFF5555, 32'hFFFF55FF, 32'hFFFFFF55, 32'hFFFFFFFF};
      home = '{32'hFF000000, 32'hFFFFFFFF, 32'hFF880000, 32'hFFAAFFEE,
               32'hFFCC44CC, 32'hFF00CC55, 32'hFF0000AA, 32'hFFEEEE77,
               32'hFFDD8855, 32'hFF664400, 32'hFFFF7777, 32'hFF333333,
               32'hFF777777, 32'hFFAAFF66, 32'hFF0088FF, 32'hFFBBBBBB};
      lvl = 8'(k * 17);
      case (p)
        PRE_RGBI: return rgbi[k];
        PRE_HOME: return home[k];
        default:  return {8'hFF, lvl, lvl, lvl};
      endcase
    endfunction

    function void fill_rows(preset_t p, int first, int last);
      for (int r = first; r <= last && r < ROWS; r++)
        for (int i = 0; i < ROW_COLORS; i++)
          row_words[r][i] = tone(p, i);
    endfunction

    function void load_cube();
      int r, g, b;
      for (int i = 0; i < GBANK_WORDS; i++) begin
        r = i / 40;
        g = (i / 5) % 8;
        b = i % 5;
        global_words[i] = {8'hFF, 8'((r * 255) / 5), 8'((g * 255) / 7), 8'((b * 255) / 4)};
      end
    endfunction

    function void apply_item(item_t it);
      result_t want;
      int wr, wi, gi, a, b, t;
      want = '0;
      wr = (it.row > ROWS - 1) ? ROWS - 1 : it.row;
      wi = (it.color_index > ROW_COLORS - 1) ? ROW_COLORS - 1 : it.color_index;
      op_tally[it.op]++;
      case (it.op)
        OP_WR_ROW: begin
          row_words[wr][wi] = it.color;
          changed = 1'b1;
        end
        OP_WR_ALL: begin
          for (int r = 0; r < ROWS; r++) row_words[r][wi] = it.color;
          changed = 1'b1;
        end
        OP_WR_GLOBAL: begin
          gi = (it.color_index < GLOBAL_BASE) ? GLOBAL_BASE : it.color_index;
          global_words[gi - GLOBAL_BASE] = it.color;
          changed = 1'b1;
        end
        OP_RD_ROW: begin
          if (it.row < ROWS && it.color_index < ROW_COLORS)
            want.read_data = row_words[it.row][it.color_index];
        end
        OP_RD_GLOBAL: begin
          if (it.color_index >= GLOBAL_BASE)
            want.read_data = global_words[it.color_index - GLOBAL_BASE];
        end
        OP_PRESET_ALL: begin
          if (it.preset == PRE_CUBE) load_cube();
          else fill_rows(it.preset, 0, ROWS - 1);
          changed = 1'b1;
        end
        OP_PRESET_ROWS: begin
          // cube over a row range leaves everything alone, flag included
          if (it.preset != PRE_CUBE) begin
            a = wr;
            b = (it.last_row > ROWS - 1) ? ROWS - 1 : it.last_row;
            if (a > b) begin
              t = a;
              a = b;
              b = t;
            end
            fill_rows(it.preset, a, b);
            changed = 1'b1;
          end
        end
        default: changed = 1'b0;
      endcase
      want.dirty = changed;
      pending_words.push_back(want);
    endfunction

    function void compare_result(result_t got);
      result_t want;
      checked++;
      if (pending_words.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("result %0d with nothing outstanding: data %h dirty %b",
                   checked, got.read_data, got.dirty);
        return;
      end
      want = pending_words.pop_front();
      if (got.read_data !== want.read_data || got.dirty !== want.dirty) begin
        errors++;
        if (errors <= 10)
          $display("result %0d mismatch: expected data %h dirty %b, got data %h dirty %b",
                   checked, want.read_data, want.dirty, got.read_data, got.dirty);
      end
    endfunction

    function int outstanding();
      return pending_words.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  item_t cmd = '0;
  logic busy;
  logic done;
  result_t result;

  palette_shadow shadow;
  int unsigned cycle_count = 0;
  bit quiet_stretch = 1'b0;

  per_row_palette_store_core uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .cmd(cmd),
    .done(done),
    .result(result)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("per_row_palette_store_core verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && done === 1'b1) shadow.compare_result(result);
  end

  function automatic item_t make_item(op_t op, logic [7:0] row, logic [7:0] last,
                                      logic [7:0] idx, logic [31:0] color, preset_t p);
    item_t it;
    it.op = op;
    it.row = row;
    it.last_row = last;
    it.color_index = idx;
    it.color = color;
    it.preset = p;
    return it;
  endfunction

  function automatic item_t random_item();
    item_t it;
    int pick;
    pick = int'($urandom_range(999));
    it.color = $urandom;
    it.preset = preset_t'($urandom_range(3));
    it.row = ($urandom_range(99) < 85) ? 8'($urandom_range(ROWS - 1))
                                       : 8'($urandom_range(255));
    it.last_row = 8'($urandom_range(255));
    it.color_index = ($urandom_range(99) < 80) ? 8'($urandom_range(15))
                                               : 8'($urandom_range(255));
    if (pick < 200) it.op = OP_WR_ROW;
    else if (pick < 260) it.op = OP_WR_ALL;
    else if (pick < 400) it.op = OP_WR_GLOBAL;
    else if (pick < 640) it.op = OP_RD_ROW;
    else if (pick < 800) it.op = OP_RD_GLOBAL;
    else if (pick < 815) it.op = OP_PRESET_ALL;
    else if (pick < 920) it.op = OP_PRESET_ROWS;
    else it.op = OP_CLEAR_DIRTY;
    if (it.op == OP_WR_GLOBAL || it.op == OP_RD_GLOBAL)
      it.color_index = ($urandom_range(99) < 85) ? 8'($urandom_range(16, 255))
                                                 : 8'($urandom_range(15));
    // mostly short ranges, either way round; now and then a wide one
    if (it.op == OP_PRESET_ROWS && $urandom_range(9) != 0)
      it.last_row = it.row + 8'($urandom_range(6)) - 8'd3;
    return it;
  endfunction

  task automatic send(item_t it);
    cmd <= it;
    start <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    shadow.apply_item(it);
  endtask

  task automatic send_idling(item_t it);
    if (!quiet_stretch && $urandom_range(99) < 19) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    send(it);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (shadow.outstanding() != 0) @(posedge clk);
  endtask

  initial begin
    item_t directed [$];
    shadow = new();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // reset contents, edges of the index space, out-of-range reads
    directed.push_back(make_item(OP_RD_ROW, 8'd0, 8'd0, 8'd6, '0, PRE_RGBI));
    directed.push_back(make_item(OP_RD_GLOBAL, 8'd0, 8'd0, 8'd16, '0, PRE_RGBI));
    directed.push_back(make_item(OP_RD_GLOBAL, 8'd0, 8'd0, 8'd255, '0, PRE_RGBI));
    directed.push_back(make_item(OP_CLEAR_DIRTY, 8'd0, 8'd0, 8'd0, '0, PRE_RGBI));
    directed.push_back(make_item(OP_RD_ROW, 8'd239, 8'd0, 8'd15, '0, PRE_RGBI));
    directed.push_back(make_item(OP_RD_ROW, 8'd240, 8'd0, 8'd0, '0, PRE_RGBI));
    directed.push_back(make_item(OP_RD_ROW, 8'd0, 8'd0, 8'd16, '0, PRE_RGBI));
    directed.push_back(make_item(OP_RD_GLOBAL, 8'd0, 8'd0, 8'd15, '0, PRE_RGBI));
    // clamped writes
    directed.push_back(make_item(OP_WR_ROW, 8'd255, 8'd255, 8'd255, 32'hFFFFFFFF, PRE_CUBE));
    directed.push_back(make_item(OP_RD_ROW, 8'd239, 8'd0, 8'd15, '0, PRE_RGBI));
    directed.push_back(make_item(OP_WR_ROW, 8'd0, 8'd0, 8'd0, 32'h00000000, PRE_RGBI));
    directed.push_back(make_item(OP_WR_GLOBAL, 8'd0, 8'd0, 8'd0, 32'h12345678, PRE_RGBI));
    directed.push_back(make_item(OP_WR_GLOBAL, 8'd0, 8'd0, 8'd255, 32'hFFFFFFFF, PRE_RGBI));
    directed.push_back(make_item(OP_RD_GLOBAL, 8'd0, 8'd0, 8'd16, '0, PRE_RGBI));
    directed.push_back(make_item(OP_WR_ALL, 8'd7, 8'd0, 8'd200, 32'hA5A5A5A5, PRE_RGBI));
    directed.push_back(make_item(OP_RD_ROW, 8'd100, 8'd0, 8'd15, '0, PRE_RGBI));
    // presets: cube over all touches only the global bank
    directed.push_back(make_item(OP_PRESET_ALL, 8'd0, 8'd0, 8'd0, '0, PRE_HOME));
    directed.push_back(make_item(OP_PRESET_ALL, 8'd0, 8'd0, 8'd0, '0, PRE_CUBE));
    directed.push_back(make_item(OP_RD_ROW, 8'd50, 8'd0, 8'd3, '0, PRE_RGBI));
    // reversed, clamped range covers every row
    directed.push_back(make_item(OP_PRESET_ROWS, 8'd255, 8'd0, 8'd0, '0, PRE_GRAY));
    directed.push_back(make_item(OP_CLEAR_DIRTY, 8'd0, 8'd0, 8'd0, '0, PRE_RGBI));
    // cube over a row range is ignored
    directed.push_back(make_item(OP_PRESET_ROWS, 8'd0, 8'd239, 8'd0, '0, PRE_CUBE));
    directed.push_back(make_item(OP_PRESET_ROWS, 8'd10, 8'd10, 8'd0, '0, PRE_RGBI));
    directed.push_back(make_item(OP_RD_ROW, 8'd10, 8'd0, 8'd9, '0, PRE_RGBI));
    directed.push_back(make_item(OP_RD_ROW, 8'd11, 8'd0, 8'd9, '0, PRE_RGBI));
    foreach (directed[i]) send(directed[i]);

    drain();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      quiet_stretch = (n >= 200 && n < 300);
      if (n % 97 == 50) drain();
      send_idling(random_item());
    end
    drain();

    repeat (20) @(posedge clk);
    shadow.errors += shadow.outstanding();

    $display("%0d items, %0d results: %0d row/%0d broadcast/%0d global writes, %0d/%0d reads",
             directed.size() + RANDOM_ITEMS, shadow.checked, shadow.op_tally[OP_WR_ROW],
             shadow.op_tally[OP_WR_ALL], shadow.op_tally[OP_WR_GLOBAL],
             shadow.op_tally[OP_RD_ROW], shadow.op_tally[OP_RD_GLOBAL]);
    $display("%0d full presets, %0d row-range presets, %0d flag clears, %0d failures",
             shadow.op_tally[OP_PRESET_ALL], shadow.op_tally[OP_PRESET_ROWS],
             shadow.op_tally[OP_CLEAR_DIRTY], shadow.errors);
    if (shadow.errors == 0) begin
      $display("per_row_palette_store_core verification clean");
    end else begin
      $display("per_row_palette_store_core verification failed");
    end
    $finish;
  end
endmodule
